### rtl/core/tse_pkg.sv
// shared types, constants and codes of the tab-to-space expander
// no dependencies; imported by every module of the block except tse_ram
package tse_pkg;

  localparam int MAX_STOPS    = 64;
  localparam int STOP_ADDR_W  = $clog2(MAX_STOPS);
  localparam int USED_W       = $clog2(MAX_STOPS + 1);
  localparam int STOP_IDX_W   = 6;
  localparam int STOP_COUNT_W = 7;
  localparam int COUNT_W      = 9;
  localparam int COL_W        = 16;
  localparam int BIT_CNT_W    = $clog2(COL_W);
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [COL_W-1:0] TAB_MASK = COL_W'(7);

  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  localparam logic [1:0] KIND_TEXT       = 2'd0;
  localparam logic [1:0] KIND_NEW_FILE   = 2'd1;
  localparam logic [1:0] KIND_STOP_WRITE = 2'd2;
  localparam logic [1:0] KIND_UNUSED     = 2'd3;

  typedef struct packed {
    logic [1:0]            kind;
    logic [7:0]            text_byte;
    logic [STOP_IDX_W-1:0] stop_index;
    logic [COUNT_W-1:0]    stop_column;
  } item_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic [COUNT_W-1:0] repeat_count;
  } res_t;

  typedef enum logic [2:0] {
    OP_CHAR,
    OP_TAB,
    OP_BACKSPACE,
    OP_NEWLINE,
    OP_NEW_FILE,
    OP_STOP_WRITE
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [7:0]            text_byte;
    logic [STOP_IDX_W-1:0] stop_index;
    logic [COUNT_W-1:0]    stop_column;
  } entry_t;

  // front to queue
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } qwr_t;

  // queue to back
  typedef struct packed {
    logic   avail;
    entry_t entry;
  } qrd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_DIV,
    B_OUT
  } bstate_t;

endpackage

### rtl/core/tse_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module tse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/tse_front.sv
// front end: accepts requests and decodes them into back-end operations
// depends on tse_pkg
module tse_front import tse_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  item_t item,
  output qwr_t  wr,
  input  logic  q_full
);

  logic   fvalid;
  logic   fvalid_next;
  entry_t fentry;
  entry_t fentry_next;
  logic   accept;
  logic   keep;
  op_t    op;

  assign full   = fvalid && q_full;
  assign accept = push && !full;

  always_comb begin
    keep = 1'b1;
    op   = OP_CHAR;
    unique case (item.kind)
      KIND_TEXT: begin
        unique case (item.text_byte)
          CH_TAB:       op = OP_TAB;
          CH_BACKSPACE: op = OP_BACKSPACE;
          CH_NEWLINE:   op = OP_NEWLINE;
          default:      op = OP_CHAR;
        endcase
      end
      KIND_NEW_FILE:   op = OP_NEW_FILE;
      KIND_STOP_WRITE: op = OP_STOP_WRITE;
      KIND_UNUSED:     keep = 1'b0;
      default:         keep = 1'b0;
    endcase
  end

  always_comb begin
    fentry_next = fentry;
    fvalid_next = fvalid && q_full;
    if (accept && keep) begin
      fvalid_next             = 1'b1;
      fentry_next.op          = op;
      fentry_next.text_byte   = item.text_byte;
      fentry_next.stop_index  = item.stop_index;
      fentry_next.stop_column = item.stop_column;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else begin
      fvalid <= fvalid_next;
    end
    fentry <= fentry_next;
  end

  assign wr.valid = fvalid && !q_full;
  assign wr.entry = fentry;

endmodule

### rtl/core/tse_queue.sv
// short operation queue between front and back end
// depends on tse_pkg
module tse_queue import tse_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  qwr_t wr,
  output logic full,
  output qrd_t rd,
  input  logic take
);

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   fill;
  logic              do_wr;
  logic              do_rd;

  assign full   = fill == (QPTR_W+1)'(QUEUE_DEPTH);
  assign do_wr  = wr.valid && !full;
  assign do_rd  = take && (fill != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= rptr + 1'b1;
      end
      fill <= fill + (QPTR_W+1)'(do_wr) - (QPTR_W+1)'(do_rd);
    end
    if (do_wr) begin
      slots[wptr] <= wr.entry;
    end
  end

  assign rd.avail = fill != '0;
  assign rd.entry = slots[rptr];

endmodule

### rtl/core/tse_back.sv
// back end: column tracking, stop table, tab width and result register
// depends on tse_pkg and tse_ram
module tse_back import tse_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [STOP_COUNT_W-1:0] stop_count,
  input  qrd_t                    rd,
  output logic                    take,
  output res_t                    result,
  output logic                    empty,
  input  logic                    pop
);

  bstate_t              state;
  bstate_t              state_next;
  entry_t               cur;
  entry_t               cur_next;
  logic [COL_W-1:0]     col;
  logic [COL_W-1:0]     col_next;
  logic [COUNT_W-1:0]   cnt;
  logic [COUNT_W-1:0]   cnt_next;
  logic [STOP_ADDR_W-1:0] idx;
  logic [STOP_ADDR_W-1:0] idx_next;
  logic [COUNT_W-1:0]   sval;
  logic [COUNT_W-1:0]   sval_next;
  logic [COUNT_W-1:0]   rem;
  logic [COUNT_W-1:0]   rem_next;
  logic [COL_W-1:0]     dvd;
  logic [COL_W-1:0]     dvd_next;
  logic [BIT_CNT_W-1:0] bitcnt;
  logic [BIT_CNT_W-1:0] bitcnt_next;
  logic                 rvalid;
  logic                 rvalid_next;
  res_t                 res_q;
  res_t                 res_next;

  logic                   we;
  logic [STOP_ADDR_W-1:0] raddr;
  logic [COUNT_W-1:0]     rdata;

  logic [USED_W-1:0]  used;
  logic               last;
  logic               hit;
  logic               out_free;
  logic [COUNT_W:0]   trial;
  logic               ge;
  logic [COUNT_W-1:0] rem_step;
  logic [COL_W:0]     sum;

  assign used = (int'(stop_count) > MAX_STOPS) ? USED_W'(MAX_STOPS) : USED_W'(stop_count);
  assign last = (USED_W'(idx) + 1'b1) == used;
  assign hit  = COL_W'(rdata) > col;
  assign out_free = !rvalid || pop;

  // one restoring-division step of col mod stop
  assign trial    = {rem, dvd[COL_W-1]};
  assign ge       = trial >= {1'b0, sval};
  assign rem_step = ge ? COUNT_W'(trial - {1'b0, sval}) : COUNT_W'(trial);

  assign sum = {1'b0, col} + (COL_W+1)'(cnt);

  tse_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (MAX_STOPS)
  ) u_stop_ram (
    .clk   (clk),
    .we    (we),
    .waddr (STOP_ADDR_W'(rd.entry.stop_index)),
    .wdata (rd.entry.stop_column),
    .raddr (raddr),
    .rdata (rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (rd.avail) begin
          unique case (rd.entry.op) inside
            OP_TAB:                             state_next = (used == '0) ? B_OUT : B_SCAN;
            OP_CHAR, OP_BACKSPACE, OP_NEWLINE:  state_next = B_OUT;
            default:                            state_next = B_IDLE;
          endcase
        end
      end
      B_SCAN: begin
        if (used == USED_W'(1)) begin
          state_next = (rdata == '0) ? B_OUT : B_DIV;
        end else if (hit || last) begin
          state_next = B_OUT;
        end
      end
      B_DIV: begin
        if (bitcnt == BIT_CNT_W'(COL_W - 1)) begin
          state_next = B_OUT;
        end
      end
      B_OUT: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    take        = 1'b0;
    we          = 1'b0;
    raddr       = '0;
    cur_next    = cur;
    col_next    = col;
    cnt_next    = cnt;
    idx_next    = idx;
    sval_next   = sval;
    rem_next    = rem;
    dvd_next    = dvd;
    bitcnt_next = bitcnt;
    rvalid_next = rvalid && !pop;
    res_next    = res_q;
    unique case (state)
      B_IDLE: begin
        take     = rd.avail;
        cur_next = rd.entry;
        idx_next = '0;
        cnt_next = COUNT_W'(1);
        if (rd.avail) begin
          unique case (rd.entry.op)
            OP_TAB: begin
              cnt_next = COUNT_W'(TAB_MASK + 1'b1) - COUNT_W'(col & TAB_MASK);
            end
            OP_NEW_FILE: col_next = '0;
            OP_STOP_WRITE: we = int'(rd.entry.stop_index) < MAX_STOPS;
            default: ;
          endcase
        end
      end
      B_SCAN: begin
        raddr    = idx + 1'b1;
        idx_next = idx + 1'b1;
        if (used == USED_W'(1)) begin
          sval_next   = rdata;
          rem_next    = '0;
          dvd_next    = col;
          bitcnt_next = '0;
          cnt_next    = COUNT_W'(1);
        end else if (hit) begin
          cnt_next = rdata - col[COUNT_W-1:0];
        end else begin
          cnt_next = COUNT_W'(1);
        end
      end
      B_DIV: begin
        rem_next    = rem_step;
        dvd_next    = {dvd[COL_W-2:0], 1'b0};
        bitcnt_next = bitcnt + 1'b1;
        cnt_next    = sval - rem_step;
      end
      B_OUT: begin
        if (out_free) begin
          rvalid_next           = 1'b1;
          res_next.out_byte     = (cur.op == OP_TAB) ? CH_SPACE : cur.text_byte;
          res_next.repeat_count = cnt;
          unique case (cur.op)
            OP_BACKSPACE: col_next = (col != '0) ? col - 1'b1 : col;
            OP_NEWLINE:   col_next = '0;
            default:      col_next = sum[COL_W] ? '1 : sum[COL_W-1:0];
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      col    <= '0;
      rvalid <= 1'b0;
    end else begin
      state  <= state_next;
      col    <= col_next;
      rvalid <= rvalid_next;
    end
    cur    <= cur_next;
    cnt    <= cnt_next;
    idx    <= idx_next;
    sval   <= sval_next;
    rem    <= rem_next;
    dvd    <= dvd_next;
    bitcnt <= bitcnt_next;
    res_q  <= res_next;
  end

  assign result = res_q;
  assign empty  = !rvalid;

endmodule

### rtl/core/tab_to_space_expander_core.sv
// top level of the tab-to-space expander
// depends on tse_pkg, tse_front, tse_queue, tse_back, tse_ram
//
// Byte stream tab expander. Each request carries a text byte, a new-file
// marker or a tab stop write; every text byte gives exactly one result
// (the byte with a repeat count of 1, or for a tab a space with the count
// that brings the column to the next stop), the other requests give none.
// Requests enter through push/full, results leave through empty/pop, and
// the front end, a four-entry operation queue and the back end decouple
// the two sides. The back end handles one request at a time: a stop write
// or new file ends in B_IDLE; a plain byte, backspace, newline or tab with
// no stops goes on to B_OUT; a tab with one nonzero stop runs a 16-step
// one-bit-per-cycle modulo of the column by the stop width in B_DIV; a tab
// with several stops reads up to 64 table entries through the single read
// port of the stop ram until one lies beyond the column or all are read.
// The front end register and the queue hold requests for the back end.
// stop_count is written through cfg_valid/cfg_ready (always ready); the
// user must write it only while the block is idle, which the block does
// not enforce; a value above 64 acts as 64. The column resets to 0; stop
// table entries are undefined until written, and no clearing pass runs.
module tab_to_space_expander_core import tse_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  // request side
  input  logic                    push,
  output logic                    full,
  input  item_t                   item,
  // result side
  output logic                    empty,
  input  logic                    pop,
  output res_t                    result,
  // stop_count register write
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [STOP_COUNT_W-1:0] cfg_data
);

  logic [STOP_COUNT_W-1:0] stop_count;
  qwr_t                    wr;
  qrd_t                    rd;
  logic                    q_full;
  logic                    take;

  // stop_count register, reset selects the every-8-columns default
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      stop_count <= cfg_data;
    end
  end

  // decode requests, drop unused kinds
  tse_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .wr     (wr),
    .q_full (q_full)
  );

  // operation queue between decode and execution
  tse_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .full (q_full),
    .rd   (rd),
    .take (take)
  );

  // column state, stop table, tab width and result register
  tse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .stop_count (stop_count),
    .rd         (rd),
    .take       (take),
    .result     (result),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

### rtl/core/tse_checker.sv
// port-level checks of the tab-to-space expander, bound to the top level
// depends on tse_pkg and tab_to_space_expander_core
module tse_checker import tse_pkg::*; (
  input logic clk,
  input logic rst,
  input logic full,
  input logic empty,
  input logic pop,
  input res_t result
);

  // no result survives reset
  a_empty_after_rst: assert property (@(posedge clk) rst |=> empty)
    else $error("result visible right after reset");

  // request side opens after reset
  a_open_after_rst: assert property (@(posedge clk) rst |=> !full)
    else $error("full right after reset");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed or vanished");

  // only a space may carry a count other than one
  a_count_one: assert property (@(posedge clk) disable iff (rst)
    !empty && result.out_byte != CH_SPACE |-> result.repeat_count == COUNT_W'(1))
    else $error("non-space result with repeat count other than one");

  // a repeat count is never zero
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    !empty |-> result.repeat_count != '0)
    else $error("zero repeat count");

endmodule

bind tab_to_space_expander_core tse_checker u_tse_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
